### rtl/lmsf_pkg.sv
// Shared types and constants for the LED matrix shadow frame writer.
// Holds command codes, driver register addresses and the word types passed
// between the front end, the frame sequencer and the queues. No dependencies.
package lmsf_pkg;

  // Command codes as they arrive on the input channel.
  localparam logic [2:0] REQ_INIT       = 3'd0;
  localparam logic [2:0] REQ_CLEAR      = 3'd1;
  localparam logic [2:0] REQ_SET_PIXEL  = 3'd2;
  localparam logic [2:0] REQ_CLR_PIXEL  = 3'd3;
  localparam logic [2:0] REQ_SET_COLUMN = 3'd4;
  localparam logic [2:0] REQ_SET_LINE   = 3'd5;
  localparam logic [2:0] REQ_INTENSITY  = 3'd6;
  localparam logic [2:0] REQ_IMAGE      = 3'd7;

  // Work classes that the sequencer knows about.
  localparam logic [1:0] OP_INIT   = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_PIXELS = 2'd2;
  localparam logic [1:0] OP_LEVEL  = 2'd3;

  // Driver register addresses and the set-up data bytes.
  localparam logic [3:0] REG_DECODE     = 4'h9;
  localparam logic [3:0] REG_INTENSITY  = 4'hA;
  localparam logic [3:0] REG_SCAN_LIMIT = 4'hB;
  localparam logic [3:0] REG_SHUTDOWN   = 4'hC;
  localparam logic [7:0] DATA_NORMAL_OP = 8'h01;
  localparam logic [7:0] DATA_SCAN_ALL  = 8'h07;
  localparam logic [7:0] DATA_NO_DECODE = 8'h00;

  // Brightness scaling: floor(p*5/83) equals (p*5*790) >> 16 for p below 256.
  localparam int unsigned LEVEL_RECIP = 790;
  localparam int unsigned LEVEL_SHIFT = 16;

  // Classified command word held between the front end and the sequencer.
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] sel;    // pixels touched, bit line*8+column
    logic [63:0] want;   // wanted pixel values, same layout
    logic [3:0]  level;  // scaled brightness for the intensity command
  } cmd_t;

  // One driver frame word.
  typedef struct packed {
    logic [3:0] frame_register;
    logic [7:0] frame_data;
    logic       last;
  } frame_t;

endpackage

### rtl/led_matrix_shadow_frame_writer_unit.sv
// Intensity gives one frame word, clear eight blank column words, and init three set-up
// words before the eight blank ones; the sequencer takes a new command only when idle.
// Pixel, column, line and image commands walk the pixels one a cycle up to the last
// changed one, giving a frame word only for a changed pixel; a full frame queue holds
// the walk at a changed pixel.
// Reset clears both queues, the sequencer and the shadow.
module led_matrix_shadow_frame_writer_unit
  import lmsf_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_req_type,
  input  logic [2:0]  in_line,
  input  logic [2:0]  in_column,
  input  logic [7:0]  in_percentage,
  input  logic [63:0] in_image,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_frame_register,
  output logic [7:0]  out_frame_data,
  output logic        out_last
);

  cmd_t   cmd;
  logic   cmd_valid;
  logic   cmd_pop;
  frame_t frame;
  logic   frame_push;
  logic   frame_full;
  frame_t out_word;

  // Command classification and queue.
  lmsf_front #(
    .DEPTH (CMD_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .full       (in_full),
    .req_type   (in_req_type),
    .line       (in_line),
    .column     (in_column),
    .percentage (in_percentage),
    .image      (in_image),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop)
  );

  // Frame sequencer with the shadow.
  lmsf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .frame      (frame),
    .frame_push (frame_push),
    .frame_full (frame_full)
  );

  // Output frame queue.
  lmsf_fifo #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (frame_push),
    .wdata (frame),
    .full  (frame_full),
    .pop   (out_pop),
    .rdata (out_word),
    .empty (out_empty)
  );

  assign out_frame_register = out_word.frame_register;
  assign out_frame_data     = out_word.frame_data;
  assign out_last           = out_word.last;

endmodule

### rtl/lmsf_fifo.sv
// Small first-in first-out queue of flat words, registers with a direct read.
// Used for the command queue and the frame queue. No package dependency.
module lmsf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (!do_push && do_pop) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/lmsf_front.sv
// Front end: classifies each command into pixel masks or a fixed sequence
// and queues the result. Depends on lmsf_pkg and lmsf_fifo.
module lmsf_front
  import lmsf_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type,
  input  logic [2:0]  line,
  input  logic [2:0]  column,
  input  logic [7:0]  percentage,
  input  logic [63:0] image,
  output cmd_t        cmd,
  output logic        cmd_valid,
  input  logic        cmd_pop
);

  cmd_t        cls;
  logic        q_empty;
  logic [10:0] pct5;
  logic [19:0] scaled;

  // Brightness scaling by a reciprocal multiply.
  assign pct5   = 11'(percentage) * 11'd5;
  assign scaled = 20'(pct5) * 20'(LEVEL_RECIP);

  // Turn the command into a class plus the set of pixels it touches.
  always_comb begin
    cls       = '0;
    cls.level = scaled[LEVEL_SHIFT +: 4];
    unique case (req_type)
      REQ_INIT: begin
        cls.op = OP_INIT;
      end
      REQ_CLEAR: begin
        cls.op = OP_CLEAR;
      end
      REQ_SET_PIXEL, REQ_CLR_PIXEL: begin
        cls.op                 = OP_PIXELS;
        cls.sel[{line, column}] = 1'b1;
        cls.want               = {64{req_type == REQ_SET_PIXEL}};
      end
      REQ_SET_COLUMN: begin
        cls.op   = OP_PIXELS;
        cls.want = '1;
        for (int i = 0; i < 8; i++) begin
          cls.sel[{3'(i), column}] = 1'b1;
        end
      end
      REQ_SET_LINE: begin
        cls.op   = OP_PIXELS;
        cls.want = '1;
        for (int j = 0; j < 8; j++) begin
          cls.sel[{line, 3'(j)}] = 1'b1;
        end
      end
      REQ_INTENSITY: begin
        cls.op = OP_LEVEL;
      end
      REQ_IMAGE: begin
        cls.op   = OP_PIXELS;
        cls.sel  = '1;
        cls.want = image;
      end
    endcase
  end

  // Command queue towards the sequencer.
  lmsf_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (q_empty)
  );

  assign cmd_valid = !q_empty;

endmodule

### rtl/lmsf_back.sv
// Back end: frame sequencer owning the 8x8 shadow; emits at most one frame
// per cycle into the frame queue unless it is full. Depends on lmsf_pkg.
module lmsf_back
  import lmsf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cmd_t   cmd,
  input  logic   cmd_valid,
  output logic   cmd_pop,
  output frame_t frame,
  output logic   frame_push,
  input  logic   frame_full
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_BLANK = 2'd2;
  localparam logic [1:0] ST_WALK  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [63:0] mask_r, mask_nxt;
  logic [63:0] want_r, want_nxt;
  logic [7:0]  shadow_r [8];
  logic [7:0]  shadow_nxt [8];
  logic [63:0] sh_flat;
  logic [63:0] rest;
  logic [7:0]  new_byte;
  logic [2:0]  wcol;
  logic [2:0]  wline;

  // Shadow viewed in the command layout, bit line*8+column.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        sh_flat[i*8 + j] = shadow_r[j][i];
      end
    end
  end

  // Pixel under the walk pointer and its updated column byte.
  assign wcol  = idx_r[2:0];
  assign wline = idx_r[5:3];
  assign rest  = mask_r & ~(64'd1 << idx_r);
  always_comb begin
    new_byte        = shadow_r[wcol];
    new_byte[wline] = want_r[idx_r];
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    mask_nxt   = mask_r;
    want_nxt   = want_r;
    shadow_nxt = shadow_r;
    cmd_pop    = 1'b0;
    frame_push = 1'b0;
    frame      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_INIT: begin
              cmd_pop   = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_SETUP;
            end
            OP_CLEAR: begin
              cmd_pop   = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_BLANK;
            end
            OP_PIXELS: begin
              cmd_pop   = 1'b1;
              idx_nxt   = '0;
              mask_nxt  = cmd.sel & (cmd.want ^ sh_flat);
              want_nxt  = cmd.want;
              state_nxt = ST_WALK;
            end
            OP_LEVEL: begin
              if (!frame_full) begin
                cmd_pop              = 1'b1;
                frame_push           = 1'b1;
                frame.frame_register = REG_INTENSITY;
                frame.frame_data     = {4'd0, cmd.level};
                frame.last           = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SETUP: begin
        if (!frame_full) begin
          frame_push = 1'b1;
          priority if (cnt_r == 3'd0) begin
            frame.frame_register = REG_SHUTDOWN;
            frame.frame_data     = DATA_NORMAL_OP;
          end else if (cnt_r == 3'd1) begin
            frame.frame_register = REG_SCAN_LIMIT;
            frame.frame_data     = DATA_SCAN_ALL;
          end else begin
            frame.frame_register = REG_DECODE;
            frame.frame_data     = DATA_NO_DECODE;
          end
          if (cnt_r == 3'd2) begin
            cnt_nxt   = '0;
            state_nxt = ST_BLANK;
          end else begin
            cnt_nxt = 3'(cnt_r + 1'b1);
          end
        end
      end
      ST_BLANK: begin
        if (!frame_full) begin
          frame_push           = 1'b1;
          frame.frame_register = {1'b0, cnt_r} + 4'd1;
          frame.frame_data     = 8'd0;
          frame.last           = (cnt_r == 3'd7);
          shadow_nxt[cnt_r]    = 8'd0;
          cnt_nxt              = 3'(cnt_r + 1'b1);
          if (cnt_r == 3'd7) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_WALK: begin
        // One pixel a cycle, a full queue stalls; only changes make a frame.
        if (mask_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (!mask_r[idx_r]) begin
          idx_nxt = 6'(idx_r + 1'b1);
        end else if (!frame_full) begin
          frame_push           = 1'b1;
          frame.frame_register = {1'b0, wcol} + 4'd1;
          frame.frame_data     = new_byte;
          frame.last           = (rest == '0);
          shadow_nxt[wcol]     = new_byte;
          mask_nxt             = rest;
          idx_nxt              = 6'(idx_r + 1'b1);
          if (rest == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      mask_r  <= '0;
      for (int c = 0; c < 8; c++) begin
        shadow_r[c] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      mask_r   <= mask_nxt;
      shadow_r <= shadow_nxt;
    end
  end

  // Wanted pixel values need no reset.
  always_ff @(posedge clk) begin
    want_r <= want_nxt;
  end

`ifndef ASSERT_OFF
  // A frame is never offered to a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    frame_push |-> !frame_full)
    else $error("frame pushed into full queue");

  // Commands leave the queue only when the sequencer is idle.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == ST_IDLE) && cmd_valid)
    else $error("command taken while busy");

  // The walk only emits for a pixel that still differs.
  a_walk_changed: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_push && state_r == ST_WALK) |-> mask_r[idx_r])
    else $error("frame for unchanged pixel");

  // After the final blank frame the whole shadow is dark.
  a_blank_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_push && state_r == ST_BLANK && frame.last) |=> (sh_flat == '0))
    else $error("shadow not cleared after blanking");
`endif

endmodule
